// ----- rtl/hsed_pkg.sv -----
// Shared constants, types and functions for the Hamming single-error decoder.
package hsed_pkg;

    localparam int MAX_CODE_BITS_DEF = 64;
    localparam int MIN_CODE_BITS     = 3;
    localparam int CW_W              = 64;
    localparam int DATA_W            = 57;
    localparam int CNT_W             = 6;
    localparam int SYN_W             = 7;
    localparam int N_W               = 7;
    localparam int ST_W              = 2;
    localparam int APB_DW            = 32;
    localparam int APB_AW            = 3;

    localparam logic [ST_W-1:0] ST_CLEAN = 2'd0;
    localparam logic [ST_W-1:0] ST_FIXED = 2'd1;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

    localparam logic           REG_CODE_LEN = 1'b0;
    localparam logic [N_W-1:0] LEN_RESET    = 7'd64;

    typedef struct packed {
        logic [N_W-1:0]   n;
        logic [SYN_W-1:0] syn;
        logic [ST_W-1:0]  status;
        logic [CNT_W-1:0] count;
    } t_meta;

    // positions j (1-based) covered by parity bit 2**k
    function automatic logic [CW_W-1:0] grp_mask(input int k);
        logic [CW_W-1:0] m;
        m = '0;
        for (int j = 1; j <= CW_W; j++) begin
            m[j-1] = ((j >> k) & 1) != 0;
        end
        return m;
    endfunction

    // number of power-of-two positions not above n
    function automatic logic [N_W-1:0] par_count(input logic [N_W-1:0] n);
        logic [N_W-1:0] c;
        c = '0;
        for (int k = 0; k < N_W; k++) begin
            if (n >= N_W'(1 << k)) begin
                c = c + N_W'(1);
            end
        end
        return c;
    endfunction

    // 0-based codeword bit of the c-th data position
    function automatic int data_pos(input int c);
        int cnt;
        int res;
        cnt = 0;
        res = 0;
        for (int j = 1; j <= CW_W; j++) begin
            if ((j & (j - 1)) != 0) begin
                if (cnt == c) begin
                    res = j - 1;
                end
                cnt = cnt + 1;
            end
        end
        return res;
    endfunction

endpackage

// ----- rtl/hsed_in_if.sv -----
// Input channel: one received codeword per word.
interface hsed_in_if;
    logic                      valid;
    logic                      ready;
    logic [hsed_pkg::CW_W-1:0] codeword;

    modport source (output valid, output codeword, input ready);
    modport sink   (input valid, input codeword, output ready);
endinterface

// ----- rtl/hsed_out_if.sv -----
// Output channel: one decoded result per word.
interface hsed_out_if;
    logic                        valid;
    logic                        ready;
    logic [hsed_pkg::DATA_W-1:0] data_bits;
    logic [hsed_pkg::CNT_W-1:0]  data_count;
    logic [hsed_pkg::SYN_W-1:0]  syndrome;
    logic [hsed_pkg::ST_W-1:0]   status;

    modport source (output valid, output data_bits, output data_count, output syndrome,
                    output status, input ready);
    modport sink   (input valid, input data_bits, input data_count, input syndrome,
                    input status, output ready);
endinterface

// ----- rtl/hsed_mask.sv -----
// Stage 1: clamp the code length and clear codeword bits above it.
module hsed_mask #(
    parameter int MAX_CODE_BITS = hsed_pkg::MAX_CODE_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [hsed_pkg::N_W-1:0]    i_len,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [hsed_pkg::CW_W-1:0]   i_codeword,
    input  logic                        i_ready,
    output logic                        o_valid,
    output hsed_pkg::t_meta             o_meta,
    output logic [MAX_CODE_BITS-1:0]    o_cw
);
    localparam logic [hsed_pkg::N_W-1:0] MAXN = hsed_pkg::N_W'(MAX_CODE_BITS);
    localparam logic [hsed_pkg::N_W-1:0] MINN = hsed_pkg::N_W'(hsed_pkg::MIN_CODE_BITS);

    logic                     r_valid;
    hsed_pkg::t_meta          r_meta;
    logic [MAX_CODE_BITS-1:0] r_cw;
    hsed_pkg::t_meta          n_meta;
    logic [MAX_CODE_BITS-1:0] n_cw;
    logic [hsed_pkg::N_W-1:0] len_eff;

    always_comb begin
        if (i_len < MINN) begin
            len_eff = MINN;
        end else if (i_len > MAXN) begin
            len_eff = MAXN;
        end else begin
            len_eff = i_len;
        end
        for (int i = 0; i < MAX_CODE_BITS; i++) begin
            n_cw[i] = i_codeword[i] && (hsed_pkg::N_W'(i) < len_eff);
        end
        n_meta        = '0;
        n_meta.n      = len_eff;
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_meta <= n_meta;
            r_cw   <= n_cw;
        end
    end

    assign o_valid = r_valid;
    assign o_meta  = r_meta;
    assign o_cw    = r_cw;
endmodule

// ----- rtl/hsed_syndrome.sv -----
// Stage 2: parity group checks forming the syndrome.
module hsed_syndrome #(
    parameter int MAX_CODE_BITS = hsed_pkg::MAX_CODE_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  hsed_pkg::t_meta             i_meta,
    input  logic [MAX_CODE_BITS-1:0]    i_cw,
    input  logic                        i_ready,
    output logic                        o_valid,
    output hsed_pkg::t_meta             o_meta,
    output logic [MAX_CODE_BITS-1:0]    o_cw
);
    logic                       r_valid;
    hsed_pkg::t_meta            r_meta;
    logic [MAX_CODE_BITS-1:0]   r_cw;
    hsed_pkg::t_meta            n_meta;
    logic [hsed_pkg::SYN_W-1:0] syn;

    for (genvar k = 0; k < hsed_pkg::SYN_W; k++) begin : g_grp
        localparam logic [hsed_pkg::CW_W-1:0] GM = hsed_pkg::grp_mask(k);
        assign syn[k] = ^(i_cw & GM[MAX_CODE_BITS-1:0]);
    end

    always_comb begin
        n_meta     = i_meta;
        n_meta.syn = syn;
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_meta <= n_meta;
            r_cw   <= i_cw;
        end
    end

    assign o_valid = r_valid;
    assign o_meta  = r_meta;
    assign o_cw    = r_cw;
endmodule

// ----- rtl/hsed_correct.sv -----
// Stage 3: single-bit correction, status and data bit count.
module hsed_correct #(
    parameter int MAX_CODE_BITS = hsed_pkg::MAX_CODE_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  hsed_pkg::t_meta             i_meta,
    input  logic [MAX_CODE_BITS-1:0]    i_cw,
    input  logic                        i_ready,
    output logic                        o_valid,
    output hsed_pkg::t_meta             o_meta,
    output logic [MAX_CODE_BITS-1:0]    o_cw
);
    logic                     r_valid;
    hsed_pkg::t_meta          r_meta;
    logic [MAX_CODE_BITS-1:0] r_cw;
    hsed_pkg::t_meta          n_meta;
    logic [MAX_CODE_BITS-1:0] n_cw;
    logic                     fix;
    logic                     nonzero;

    always_comb begin
        nonzero = i_meta.syn != '0;
        fix     = nonzero && (i_meta.syn <= i_meta.n);
        for (int i = 0; i < MAX_CODE_BITS; i++) begin
            n_cw[i] = i_cw[i] ^ (fix && (i_meta.syn == hsed_pkg::SYN_W'(i + 1)));
        end
        n_meta       = i_meta;
        n_meta.count = hsed_pkg::CNT_W'(i_meta.n - hsed_pkg::par_count(i_meta.n));
        if (!nonzero) begin
            n_meta.status = hsed_pkg::ST_CLEAN;
        end else if (fix) begin
            n_meta.status = hsed_pkg::ST_FIXED;
        end else begin
            n_meta.status = hsed_pkg::ST_RANGE;
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_meta <= n_meta;
            r_cw   <= n_cw;
        end
    end

    assign o_valid = r_valid;
    assign o_meta  = r_meta;
    assign o_cw    = r_cw;

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !i_ready |=> r_valid && $stable(r_cw) && $stable(r_meta))
        else $error("stalled word changed in correction stage");

    a_clean_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> ((r_meta.syn == '0) == (r_meta.status == hsed_pkg::ST_CLEAN)))
        else $error("status and syndrome disagree");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_meta.status == hsed_pkg::ST_RANGE |-> r_meta.syn > r_meta.n)
        else $error("out-of-range flag with syndrome inside code");

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> hsed_pkg::N_W'(r_meta.count) < r_meta.n)
        else $error("data count not below code length");
endmodule

// ----- rtl/hsed_pack.sv -----
// Stage 4: drop parity positions and pack data bits into the output register.
module hsed_pack #(
    parameter int MAX_CODE_BITS = hsed_pkg::MAX_CODE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  hsed_pkg::t_meta               i_meta,
    input  logic [MAX_CODE_BITS-1:0]      i_cw,
    input  logic                          i_ready,
    output logic                          o_valid,
    output hsed_pkg::t_meta               o_meta,
    output logic [hsed_pkg::DATA_W-1:0]   o_data
);
    localparam int DW = MAX_CODE_BITS
                        - int'(hsed_pkg::par_count(hsed_pkg::N_W'(MAX_CODE_BITS)));

    logic                        r_valid;
    hsed_pkg::t_meta             r_meta;
    logic [hsed_pkg::DATA_W-1:0] r_data;
    logic [hsed_pkg::DATA_W-1:0] n_data;

    for (genvar c = 0; c < hsed_pkg::DATA_W; c++) begin : g_bit
        if (c < DW) begin : g_use
            localparam int P = hsed_pkg::data_pos(c);
            assign n_data[c] = i_cw[P];
        end else begin : g_pad
            assign n_data[c] = 1'b0;
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_meta <= i_meta;
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_meta  = r_meta;
    assign o_data  = r_data;
endmodule

// ----- rtl/hamming_single_error_decoder.sv -----
// Hamming single-error-correcting decoder, top level.
// Pipeline: 4 register stages (mask, syndrome, correct, pack), each with its own valid bit;
// the pack register holds the result and drives the output channel.
// Throughput: one word per cycle while the output is ready; a stalled output only holds
// the words behind it, and bubbles are squeezed out.
// Reset: synchronous, active low; clears all stage valid bits and sets code_length to 64.
module hamming_single_error_decoder #(
    parameter int MAX_CODE_BITS = hsed_pkg::MAX_CODE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [hsed_pkg::APB_AW-1:0]   paddr,
    input  logic [hsed_pkg::APB_DW-1:0]   pwdata,
    output logic [hsed_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    hsed_in_if.sink                       i_cw,
    hsed_out_if.source                    o_res
);
    logic [hsed_pkg::N_W-1:0] r_len;

    logic                     s1_valid, s1_ready;
    logic                     s2_valid, s2_ready;
    logic                     s3_valid, s3_ready;
    hsed_pkg::t_meta          s1_meta, s2_meta, s3_meta, s4_meta;
    logic [MAX_CODE_BITS-1:0] s1_cw, s2_cw, s3_cw;
    logic                     cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == hsed_pkg::REG_CODE_LEN);
    assign prdata = (paddr[2] == hsed_pkg::REG_CODE_LEN)
                    ? hsed_pkg::APB_DW'(r_len) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= hsed_pkg::LEN_RESET;
        end else if (cfg_wr) begin
            r_len <= pwdata[hsed_pkg::N_W-1:0];
        end
    end

    hsed_mask #(.MAX_CODE_BITS(MAX_CODE_BITS)) u_mask (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_len      (r_len),
        .i_valid    (i_cw.valid),
        .o_ready    (i_cw.ready),
        .i_codeword (i_cw.codeword),
        .i_ready    (s1_ready),
        .o_valid    (s1_valid),
        .o_meta     (s1_meta),
        .o_cw       (s1_cw)
    );

    hsed_syndrome #(.MAX_CODE_BITS(MAX_CODE_BITS)) u_syndrome (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .o_ready (s1_ready),
        .i_meta  (s1_meta),
        .i_cw    (s1_cw),
        .i_ready (s2_ready),
        .o_valid (s2_valid),
        .o_meta  (s2_meta),
        .o_cw    (s2_cw)
    );

    hsed_correct #(.MAX_CODE_BITS(MAX_CODE_BITS)) u_correct (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s2_valid),
        .o_ready (s2_ready),
        .i_meta  (s2_meta),
        .i_cw    (s2_cw),
        .i_ready (s3_ready),
        .o_valid (s3_valid),
        .o_meta  (s3_meta),
        .o_cw    (s3_cw)
    );

    hsed_pack #(.MAX_CODE_BITS(MAX_CODE_BITS)) u_pack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s3_valid),
        .o_ready (s3_ready),
        .i_meta  (s3_meta),
        .i_cw    (s3_cw),
        .i_ready (o_res.ready),
        .o_valid (o_res.valid),
        .o_meta  (s4_meta),
        .o_data  (o_res.data_bits)
    );

    assign o_res.data_count = s4_meta.count;
    assign o_res.syndrome   = s4_meta.syn;
    assign o_res.status     = s4_meta.status;
endmodule

// ----- tb/tb_hamming_single_error_decoder.sv -----
// Testbench for the Hamming single-error decoder with an in-bench decoder as checker.
module tb_hamming_single_error_decoder;

    localparam int RESET_CYCLES     = 9;
    localparam int MAX_GAP          = 9;
    localparam int SETTLE_CYCLES    = 8;
    localparam int DRAIN_LIMIT      = 4000;
    localparam int HOLD_CYCLES      = 60;
    localparam int ITEMS_PER_LENGTH = 70;
    localparam int PRESSURE_ITEMS   = 150;
    localparam int RANDOM_LENGTHS   = 6;
    localparam logic [hsed_pkg::APB_AW-1:0] ADDR_CODE_LEN = {hsed_pkg::REG_CODE_LEN, 2'b00};

    typedef struct packed {
        logic [hsed_pkg::DATA_W-1:0] data_bits;
        logic [hsed_pkg::CNT_W-1:0]  data_count;
        logic [hsed_pkg::SYN_W-1:0]  syndrome;
        logic [hsed_pkg::ST_W-1:0]   status;
    } t_decoded;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [hsed_pkg::APB_AW-1:0] paddr;
    logic [hsed_pkg::APB_DW-1:0] pwdata;
    logic [hsed_pkg::APB_DW-1:0] prdata;
    logic                        pready;

    hsed_in_if  cw_if ();
    hsed_out_if res_if ();

    logic [hsed_pkg::N_W-1:0] len_shadow;
    t_decoded                 decoded_q[$];
    t_decoded                 head;
    int                       error_count;
    bit                       idle_on;
    bit                       hold_req;

    int sweep_lengths[$] = '{1, 3, 4, 5, 6, 7, 8, 9, 15, 16, 17, 31, 32, 33, 48, 57, 63, 64, 100};
    int flip_positions[$] = '{1, 2, 3, 32, 57, 63, 64};
    int clamp_lengths[$] = '{0, 2, 65, 127};

    hamming_single_error_decoder i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_cw    (cw_if),
        .o_res   (res_if)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    function automatic int used_length(input logic [hsed_pkg::N_W-1:0] len);
        int n;
        n = int'(len);
        if (n < hsed_pkg::MIN_CODE_BITS) begin
            n = hsed_pkg::MIN_CODE_BITS;
        end
        if (n > hsed_pkg::CW_W) begin
            n = hsed_pkg::CW_W;
        end
        return n;
    endfunction

    function automatic t_decoded decode_word(input logic [hsed_pkg::CW_W-1:0] raw,
                                             input logic [hsed_pkg::N_W-1:0] len);
        t_decoded                  r;
        logic [hsed_pkg::CW_W-1:0] cw;
        logic                      par;
        int                        n;
        int                        syn;
        int                        cnt;
        n = used_length(len);
        cw = raw;
        for (int j = n; j < hsed_pkg::CW_W; j++) begin
            cw[j] = 1'b0;
        end
        syn = 0;
        for (int p = 1; p <= n; p = p << 1) begin
            par = 1'b0;
            for (int j = 1; j <= n; j++) begin
                if ((j & p) != 0) begin
                    par = par ^ cw[j-1];
                end
            end
            if (par) begin
                syn = syn + p;
            end
        end
        r.syndrome = hsed_pkg::SYN_W'(syn);
        r.status = hsed_pkg::ST_CLEAN;
        if (syn != 0 && syn <= n) begin
            cw[syn-1] = ~cw[syn-1];
            r.status = hsed_pkg::ST_FIXED;
        end else if (syn != 0) begin
            r.status = hsed_pkg::ST_RANGE;
        end
        r.data_bits = '0;
        cnt = 0;
        for (int j = 1; j <= n; j++) begin
            if ((j & (j - 1)) != 0) begin
                r.data_bits[cnt] = cw[j-1];
                cnt = cnt + 1;
            end
        end
        r.data_count = hsed_pkg::CNT_W'(cnt);
        return r;
    endfunction

    // random payload, parity fixed up, then the requested number of bit flips
    function automatic logic [hsed_pkg::CW_W-1:0] build_codeword(
            input logic [hsed_pkg::N_W-1:0] len, input int errors);
        logic [hsed_pkg::CW_W-1:0] cw;
        t_decoded                  d;
        int                        n;
        int                        pos;
        int                        prev;
        n = used_length(len);
        cw = {$urandom, $urandom};
        d = decode_word(cw, len);
        for (int p = 1; p <= n; p = p << 1) begin
            if ((d.syndrome & p) != 0) begin
                cw[p-1] = ~cw[p-1];
            end
        end
        prev = 0;
        for (int e = 0; e < errors; e++) begin
            do begin
                pos = $urandom_range(1, n);
            end while (pos == prev);
            cw[pos-1] = ~cw[pos-1];
            prev = pos;
        end
        return cw;
    endfunction

    function automatic logic [hsed_pkg::CW_W-1:0] random_codeword(
            input logic [hsed_pkg::N_W-1:0] len);
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 9) begin
            return build_codeword(len, 0);
        end else if (pick < 16) begin
            return build_codeword(len, 1);
        end else if (pick < 18) begin
            return build_codeword(len, 2);
        end
        return {$urandom, $urandom};
    endfunction

    task automatic report_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            error_count++;
        end
    endtask

    task automatic send_codeword(input logic [hsed_pkg::CW_W-1:0] cw);
        int gap;
        gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            cw_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        cw_if.valid    <= 1'b1;
        cw_if.codeword <= cw;
        do @(posedge i_clk); while (!cw_if.ready);
        decoded_q = {decoded_q, decode_word(cw, len_shadow)};
        @(negedge i_clk);
    endtask

    // drop valid, wait for every result, then let the pipeline settle
    task automatic finish_phase();
        int k;
        cw_if.valid <= 1'b0;
        k = 0;
        while (decoded_q.size() != 0 && k < DRAIN_LIMIT) begin
            @(negedge i_clk);
            k++;
        end
        if (decoded_q.size() != 0) begin
            $display("%0t: results missing, expected %0d more, actual 0",
                     $time, decoded_q.size());
            error_count++;
            decoded_q.delete();
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_code_length(input logic [hsed_pkg::N_W-1:0] len);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_CODE_LEN;
        pwdata  <= ($urandom << hsed_pkg::N_W) | hsed_pkg::APB_DW'(len);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        len_shadow = len;
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[hsed_pkg::N_W-1:0] !== len) begin
            $display("%0t: code_length readback mismatch, expected %h, actual %h",
                     $time, len, prdata[hsed_pkg::N_W-1:0]);
            error_count++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic test_full_length_cases();
        logic [hsed_pkg::CW_W-1:0] base;
        idle_on = 1'b0;
        send_codeword('0);
        send_codeword('1);
        send_codeword(build_codeword(len_shadow, 0));
        foreach (flip_positions[i]) begin
            base = build_codeword(len_shadow, 0);
            send_codeword(base ^ (64'd1 << (flip_positions[i] - 1)));
        end
        // two flips whose syndrome lands past the code end
        base = build_codeword(len_shadow, 0);
        send_codeword(base ^ (64'd1 << 62) ^ (64'd1 << 63));
        // two flips that alias onto a third position
        base = build_codeword(len_shadow, 0);
        send_codeword(base ^ 64'd3);
        send_codeword(64'hAAAA_AAAA_AAAA_AAAA);
        send_codeword(64'h5555_5555_5555_5555);
        finish_phase();
    endtask

    task automatic test_length_clamp();
        idle_on = 1'b1;
        foreach (clamp_lengths[i]) begin
            write_code_length(hsed_pkg::N_W'(clamp_lengths[i]));
            send_codeword('1);
            send_codeword(build_codeword(len_shadow, 1));
            send_codeword({$urandom, $urandom});
            finish_phase();
        end
    endtask

    task automatic test_length_sweep();
        foreach (sweep_lengths[i]) begin
            write_code_length(hsed_pkg::N_W'(sweep_lengths[i]));
            idle_on = ($urandom_range(0, 3) != 0);
            repeat (ITEMS_PER_LENGTH) send_codeword(random_codeword(len_shadow));
            finish_phase();
        end
    endtask

    task automatic test_random_lengths();
        repeat (RANDOM_LENGTHS) begin
            write_code_length(hsed_pkg::N_W'($urandom_range(0, 127)));
            idle_on = ($urandom_range(0, 3) != 0);
            repeat (ITEMS_PER_LENGTH) send_codeword(random_codeword(len_shadow));
            finish_phase();
        end
    endtask

    task automatic test_output_backpressure();
        write_code_length(hsed_pkg::LEN_RESET);
        idle_on  = 1'b0;
        hold_req = 1'b1;
        repeat (PRESSURE_ITEMS / 2) send_codeword(random_codeword(len_shadow));
        hold_req = 1'b1;
        repeat (PRESSURE_ITEMS / 2) send_codeword(random_codeword(len_shadow));
        finish_phase();
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (decoded_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h %h %h %h", $time,
                         res_if.data_bits, res_if.data_count, res_if.syndrome, res_if.status);
                error_count++;
            end else begin
                head = decoded_q.pop_front();
                report_field("data_bits", 64'(head.data_bits), 64'(res_if.data_bits));
                report_field("data_count", 64'(head.data_count), 64'(res_if.data_count));
                report_field("syndrome", 64'(head.syndrome), 64'(res_if.syndrome));
                report_field("status", 64'(head.status), 64'(res_if.status));
            end
        end
    end

    initial begin : result_sink
        int gap;
        res_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
            if (gap > 0) begin
                res_if.ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge i_clk); while (!res_if.valid);
            @(negedge i_clk);
        end
    end

    initial begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        i_rst_n        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        cw_if.valid    = 1'b0;
        cw_if.codeword = '0;
        idle_on        = 1'b0;
        hold_req       = 1'b0;
        error_count    = 0;
        len_shadow     = hsed_pkg::LEN_RESET;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_full_length_cases();
        test_length_clamp();
        test_length_sweep();
        test_random_lengths();
        test_output_backpressure();
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/hsed_pkg.sv
rtl/hsed_in_if.sv
rtl/hsed_out_if.sv
rtl/hsed_mask.sv
rtl/hsed_syndrome.sv
rtl/hsed_correct.sv
rtl/hsed_pack.sv
rtl/hamming_single_error_decoder.sv
tb/tb_hamming_single_error_decoder.sv
